// ===== sv/msvm_pkg.sv =====
// Shared types and constants for the membrane slab voxel mask.
// No dependencies; the top level imports this package.
`timescale 1ns / 1ps
`default_nettype none

package msvm_pkg;

  localparam int LVL_W      = 16;
  localparam int CHG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = LVL_W + CHG_W;
  localparam int PIPE_DEPTH = 6;

  // Reset values of the thickness and protein dielectric registers.
  localparam int LEN_RESET = 7680;
  localparam int PD_RESET  = 2560;

  // A margin of 0.05 is 12.8 LSB; on integer levels it becomes "greater than pd + 12".
  localparam logic [LVL_W:0]   DIE_MARGIN = 17'd12;
  // Bilayer dielectric 2.0 with 8 fraction bits.
  localparam logic [LVL_W-1:0] MEM_DIE    = 16'd512;

  localparam logic CMD_DIELECTRIC = 1'b0;
  localparam logic CMD_KAPPA      = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROT_DIE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_TOP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_BOT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE   = 3'd7;

  // Per-item fields that ride alongside the geometry pipeline.
  typedef struct packed {
    logic             cmd;
    logic             slab;
    logic             below;
    logic             lvl_hi;
    logic [LVL_W-1:0] level;
    logic [CHG_W-1:0] charge;
  } sb_t;

endpackage

`default_nettype wire

// ===== sv/membrane_slab_voxel_mask_core.sv =====
// Membrane slab voxel mask, top level: configuration registers, input skid
// buffer, item sideband pipeline and output register. Uses msvm_pkg,
// msvm_geom and msvm_cmp.
//
// Each item is one grid point; the block takes one item per clock while the
// output side does not stall and returns exactly one result per item, in order.
// Each item passes through six datapath stages (offsets, squares and products,
// sums, half-width partial products of the two wide products, their reassembly,
// the final compare) and then the output register.
// A stall on the result side freezes the whole pipeline; in_tready comes from
// a register, and one item is held in an input skid buffer while stalled.
// Registers must only be written while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module membrane_slab_voxel_mask_core #(
  parameter int COORD_WIDTH = 24,
  localparam int IN_FIELDS_W = 3 * COORD_WIDTH + msvm_pkg::LVL_W + msvm_pkg::CHG_W,
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input item.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: coord_x, coord_y, coord_z, level_in, charge_in, zero fill.
  input  logic [IN_DATA_W-1:0]              in_tdata,
  // tuser: command.
  input  logic                              in_tuser,
  // Result item.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: level_out, charge_out.
  output logic [msvm_pkg::OUT_DATA_W-1:0]   out_tdata,
  // tuser: charge_changed.
  output logic                              out_tuser,
  // Register writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [msvm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msvm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import msvm_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam logic [W-2:0]   LEN_RST = (W-1)'(LEN_RESET);
  localparam logic [LVL_W-1:0] PD_RST = LVL_W'(PD_RESET);

  // ---------------- Configuration registers ----------------
  logic [W-1:0]     bottom_r, axis_x_r, axis_y_r;
  logic [W-2:0]     length_r, rad_top_r, rad_bot_r;
  logic [LVL_W-1:0] prot_die_r;
  logic [CHG_W-1:0] mcharge_r;
  logic             cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bottom_r   <= '0;
      length_r   <= LEN_RST;
      prot_die_r <= PD_RST;
      rad_top_r  <= '0;
      rad_bot_r  <= '0;
      axis_x_r   <= '0;
      axis_y_r   <= '0;
      mcharge_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_BOTTOM:   bottom_r   <= cfg_data[W-1:0];
        REG_LENGTH:   length_r   <= cfg_data[W-2:0];
        REG_PROT_DIE: prot_die_r <= cfg_data[LVL_W-1:0];
        REG_RAD_TOP:  rad_top_r  <= cfg_data[W-2:0];
        REG_RAD_BOT:  rad_bot_r  <= cfg_data[W-2:0];
        REG_AXIS_X:   axis_x_r   <= cfg_data[W-1:0];
        REG_AXIS_Y:   axis_y_r   <= cfg_data[W-1:0];
        REG_CHARGE:   mcharge_r  <= cfg_data[CHG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- Input skid and pipeline enable ----------------
  logic                 pipe_en, in_acc, src_valid;
  logic                 skid_full_r, skid_full_nxt;
  logic [IN_DATA_W-1:0] skid_data_r, src_data;
  logic                 skid_user_r, src_user;
  logic                 out_tvalid_r;

  assign pipe_en   = ~out_tvalid_r | out_tready;
  assign in_tready = ~skid_full_r;
  assign in_acc    = in_tvalid & in_tready;

  assign src_valid = skid_full_r | in_acc;
  assign src_data  = skid_full_r ? skid_data_r : in_tdata;
  assign src_user  = skid_full_r ? skid_user_r : in_tuser;

  always_comb begin
    if (pipe_en) begin
      skid_full_nxt = 1'b0;
    end else begin
      skid_full_nxt = skid_full_r | in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else begin
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !pipe_en) begin
      skid_data_r <= in_tdata;
      skid_user_r <= in_tuser;
    end
  end

  // ---------------- Field unpacking and slab flags ----------------
  logic [W-1:0]     src_x, src_y, src_z;
  logic [LVL_W-1:0] src_level;
  logic [CHG_W-1:0] src_charge;
  logic signed [W:0] z_ext, bot_ext, top_ext;
  logic [LVL_W:0]   die_lim;
  sb_t              sb_nxt;

  assign src_x      = src_data[0 +: W];
  assign src_y      = src_data[W +: W];
  assign src_z      = src_data[2*W +: W];
  assign src_level  = src_data[3*W +: LVL_W];
  assign src_charge = src_data[3*W+LVL_W +: CHG_W];

  assign z_ext   = {src_z[W-1], src_z};
  assign bot_ext = {bottom_r[W-1], bottom_r};
  assign top_ext = bot_ext + $signed({2'b00, length_r});
  assign die_lim = {1'b0, prot_die_r} + DIE_MARGIN;

  always_comb begin
    sb_nxt.cmd    = src_user;
    // A zero thickness leaves every point outside the membrane.
    sb_nxt.slab   = (length_r != '0) && (z_ext >= bot_ext) && (z_ext <= top_ext);
    sb_nxt.below  = (z_ext <= bot_ext);
    sb_nxt.lvl_hi = ({1'b0, src_level} > die_lim);
    sb_nxt.level  = src_level;
    sb_nxt.charge = src_charge;
  end

  // ---------------- Datapath ----------------
  logic [2*W:0]   dist_sq;
  logic [2*W-2:0] rad_len;
  logic [2*W-3:0] len_sq;
  logic           dist_gt;

  msvm_geom #(
    .COORD_WIDTH (W)
  ) u_geom (
    .clk           (clk),
    .en            (pipe_en),
    .coord_x       (src_x),
    .coord_y       (src_y),
    .coord_z       (src_z),
    .bottom        (bottom_r),
    .axis_x        (axis_x_r),
    .axis_y        (axis_y_r),
    .length        (length_r),
    .radius_top    (rad_top_r),
    .radius_bottom (rad_bot_r),
    .dist_sq       (dist_sq),
    .rad_len       (rad_len),
    .len_sq        (len_sq)
  );

  msvm_cmp #(
    .COORD_WIDTH (W)
  ) u_cmp (
    .clk     (clk),
    .en      (pipe_en),
    .dist_sq (dist_sq),
    .rad_len (rad_len),
    .len_sq  (len_sq),
    .dist_gt (dist_gt)
  );

  // ---------------- Sideband pipeline ----------------
  logic [PIPE_DEPTH-1:0] vld_r;
  sb_t                   sb_r [PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], src_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sb_r[0] <= sb_nxt;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // ---------------- Result rules and output register ----------------
  sb_t              sb_last;
  logic             in_mem;
  logic [LVL_W-1:0] level_nxt, out_level_r;
  logic [CHG_W-1:0] charge_nxt, out_charge_r;
  logic             changed_nxt, out_changed_r;

  assign sb_last = sb_r[PIPE_DEPTH-1];
  assign in_mem  = sb_last.slab & dist_gt;

  always_comb begin
    level_nxt   = sb_last.level;
    charge_nxt  = sb_last.charge;
    changed_nxt = 1'b0;
    if (sb_last.cmd == CMD_KAPPA) begin
      if (sb_last.below && (sb_last.level != '0)) begin
        charge_nxt  = mcharge_r;
        changed_nxt = 1'b1;
      end
      if (in_mem) begin
        level_nxt = '0;
      end
    end else if (in_mem && sb_last.lvl_hi) begin
      level_nxt = MEM_DIE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (pipe_en) begin
      out_tvalid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_level_r   <= level_nxt;
      out_charge_r  <= charge_nxt;
      out_changed_r <= changed_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_charge_r, out_level_r};
  assign out_tuser  = out_changed_r;

  // ---------------- Assertions ----------------
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r) && $stable(out_tvalid_r))
    else $error("pipeline valid bits moved during a stall");

  a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !pipe_en |=> skid_full_r)
    else $error("item accepted during a stall was not held in the skid buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r && pipe_en |=> vld_r[0] && !skid_full_r)
    else $error("skid buffer item did not enter the pipeline");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[PIPE_DEPTH-1] && pipe_en |=> out_tvalid_r)
    else $error("item at the last stage did not reach the output register");

endmodule

`default_nettype wire

// ===== sv/msvm_geom.sv =====
// First three pipeline stages: distances to the pore axis, squares and the
// radius-times-thickness products. Pure datapath; stalls through en.
`timescale 1ns / 1ps
`default_nettype none

module msvm_geom #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [COORD_WIDTH-1:0]   coord_x,
  input  logic [COORD_WIDTH-1:0]   coord_y,
  input  logic [COORD_WIDTH-1:0]   coord_z,
  input  logic [COORD_WIDTH-1:0]   bottom,
  input  logic [COORD_WIDTH-1:0]   axis_x,
  input  logic [COORD_WIDTH-1:0]   axis_y,
  input  logic [COORD_WIDTH-2:0]   length,
  input  logic [COORD_WIDTH-2:0]   radius_top,
  input  logic [COORD_WIDTH-2:0]   radius_bottom,
  output logic [2*COORD_WIDTH:0]   dist_sq,
  output logic [2*COORD_WIDTH-2:0] rad_len,
  output logic [2*COORD_WIDTH-3:0] len_sq
);

  localparam int W = COORD_WIDTH;

  // Stage A: absolute offsets from the axis and heights above bottom / below top.
  logic [W:0]   dx_w, dy_w, negx_w, negy_w;
  logic [W-1:0] zdiff_w, ztop_w;
  logic [W-1:0] ux_nxt, uy_nxt, ux_a_r, uy_a_r;
  logic [W-2:0] zb_nxt, tz_nxt, zb_a_r, tz_a_r;

  assign dx_w   = {coord_x[W-1], coord_x} - {axis_x[W-1], axis_x};
  assign dy_w   = {coord_y[W-1], coord_y} - {axis_y[W-1], axis_y};
  assign negx_w = ~dx_w + {{W{1'b0}}, 1'b1};
  assign negy_w = ~dy_w + {{W{1'b0}}, 1'b1};
  // The difference of two W-bit signed values has magnitude below 2^W.
  assign ux_nxt = dx_w[W] ? negx_w[W-1:0] : dx_w[W-1:0];
  assign uy_nxt = dy_w[W] ? negy_w[W-1:0] : dy_w[W-1:0];
  // Both heights only matter inside the slab, where they lie in [0, length].
  assign zdiff_w = coord_z - bottom;
  assign ztop_w  = bottom + {1'b0, length} - coord_z;
  assign zb_nxt  = zdiff_w[W-2:0];
  assign tz_nxt  = ztop_w[W-2:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ux_a_r <= ux_nxt;
      uy_a_r <= uy_nxt;
      zb_a_r <= zb_nxt;
      tz_a_r <= tz_nxt;
    end
  end

  // Stage B: one multiplier per term.
  logic [2*W-1:0] sqx_nxt, sqy_nxt, sqx_b_r, sqy_b_r;
  logic [2*W-3:0] pr1_nxt, pr0_nxt, lsq_nxt, pr1_b_r, pr0_b_r, lsq_b_r;

  assign sqx_nxt = {{W{1'b0}}, ux_a_r} * {{W{1'b0}}, ux_a_r};
  assign sqy_nxt = {{W{1'b0}}, uy_a_r} * {{W{1'b0}}, uy_a_r};
  assign pr1_nxt = {{(W-1){1'b0}}, radius_top} * {{(W-1){1'b0}}, zb_a_r};
  assign pr0_nxt = {{(W-1){1'b0}}, radius_bottom} * {{(W-1){1'b0}}, tz_a_r};
  assign lsq_nxt = {{(W-1){1'b0}}, length} * {{(W-1){1'b0}}, length};

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_b_r <= sqx_nxt;
      sqy_b_r <= sqy_nxt;
      pr1_b_r <= pr1_nxt;
      pr0_b_r <= pr0_nxt;
      lsq_b_r <= lsq_nxt;
    end
  end

  // Stage C: squared distance and radius times thickness.
  logic [2*W:0]   dist_nxt, dist_c_r;
  logic [2*W-2:0] rad_nxt, rad_c_r;
  logic [2*W-3:0] lsq_c_r;

  assign dist_nxt = {1'b0, sqx_b_r} + {1'b0, sqy_b_r};
  assign rad_nxt  = {1'b0, pr1_b_r} + {1'b0, pr0_b_r};

  always_ff @(posedge clk) begin
    if (en) begin
      dist_c_r <= dist_nxt;
      rad_c_r  <= rad_nxt;
      lsq_c_r  <= lsq_b_r;
    end
  end

  assign dist_sq = dist_c_r;
  assign rad_len = rad_c_r;
  assign len_sq  = lsq_c_r;

endmodule

`default_nettype wire

// ===== sv/msvm_cmp.sv =====
// Last three pipeline stages: the exact test dist^2 * len^2 > (radius * len)^2,
// with both wide products split into half-width partial products.
`timescale 1ns / 1ps
`default_nettype none

module msvm_cmp #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [2*COORD_WIDTH:0]   dist_sq,
  input  logic [2*COORD_WIDTH-2:0] rad_len,
  input  logic [2*COORD_WIDTH-3:0] len_sq,
  output logic                     dist_gt
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = 4 * W - 1;

  // Stage D: partial products on halves split at bit W.
  logic [W:0]   dh_w;
  logic [W-1:0] dl_w, ll_w, nl_w;
  logic [W-3:0] lh_w;
  logic [W-2:0] nh_w;

  assign dh_w = dist_sq[2*W:W];
  assign dl_w = dist_sq[W-1:0];
  assign lh_w = len_sq[2*W-3:W];
  assign ll_w = len_sq[W-1:0];
  assign nh_w = rad_len[2*W-2:W];
  assign nl_w = rad_len[W-1:0];

  logic [2*W-2:0] p_hh_nxt, p_hh_r;
  logic [2*W:0]   p_hl_nxt, p_hl_r;
  logic [2*W-3:0] p_lh_nxt, p_lh_r;
  logic [2*W-1:0] p_ll_nxt, p_ll_r;
  logic [2*W-3:0] q_hh_nxt, q_hh_r;
  logic [2*W-2:0] q_hl_nxt, q_hl_r;
  logic [2*W-1:0] q_ll_nxt, q_ll_r;

  assign p_hh_nxt = {{(W-2){1'b0}}, dh_w} * {{(W+1){1'b0}}, lh_w};
  assign p_hl_nxt = {{W{1'b0}}, dh_w} * {{(W+1){1'b0}}, ll_w};
  assign p_lh_nxt = {{(W-2){1'b0}}, dl_w[W-1:0]} * {{W{1'b0}}, lh_w} ;
  assign p_ll_nxt = {{W{1'b0}}, dl_w} * {{W{1'b0}}, ll_w};
  assign q_hh_nxt = {{(W-1){1'b0}}, nh_w} * {{(W-1){1'b0}}, nh_w};
  assign q_hl_nxt = {{(W-1){1'b0}}, nl_w} * {{W{1'b0}}, nh_w};
  assign q_ll_nxt = {{W{1'b0}}, nl_w} * {{W{1'b0}}, nl_w};

  always_ff @(posedge clk) begin
    if (en) begin
      p_hh_r <= p_hh_nxt;
      p_hl_r <= p_hl_nxt;
      p_lh_r <= p_lh_nxt;
      p_ll_r <= p_ll_nxt;
      q_hh_r <= q_hh_nxt;
      q_hl_r <= q_hl_nxt;
      q_ll_r <= q_ll_nxt;
    end
  end

  // Stage E: reassemble both full products.
  logic [2*W+1:0] mid_w;
  logic [PW-1:0]  lhs_nxt, rhs_nxt, lhs_r, rhs_r;

  assign mid_w = {1'b0, p_hl_r} + {4'b0000, p_lh_r};

  assign lhs_nxt = {p_hh_r, {(2*W){1'b0}}}
                 + {{(W-3){1'b0}}, mid_w, {W{1'b0}}}
                 + {{(2*W-1){1'b0}}, p_ll_r};
  // The cross term of a square appears twice, hence the extra shift.
  assign rhs_nxt = {1'b0, q_hh_r, {(2*W){1'b0}}}
                 + {{(W-1){1'b0}}, q_hl_r, {(W+1){1'b0}}}
                 + {{(2*W-1){1'b0}}, q_ll_r};

  always_ff @(posedge clk) begin
    if (en) begin
      lhs_r <= lhs_nxt;
      rhs_r <= rhs_nxt;
    end
  end

  // Stage F: strict compare, so a point on the pore radius is not excluded.
  logic gt_r;

  always_ff @(posedge clk) begin
    if (en) begin
      gt_r <= (lhs_r > rhs_r);
    end
  end

  assign dist_gt = gt_r;

endmodule

`default_nettype wire
